>>> sv/fdt_pkg.sv
// Package for the device-tree root model classifier.
// Holds constants, verdict codes and the model string tables; no dependencies.
package fdt_pkg;

    localparam int BlobDepthDef   = 65536;
    localparam int ModelMaxDef    = 64;
    localparam int HeaderBytesDef = 64;

    localparam logic [31:0] FdtMagic = 32'hd00dfeed;
    localparam logic [31:0] TokBegin = 32'd1;
    localparam logic [31:0] TokEndNode = 32'd2;
    localparam logic [31:0] TokProp = 32'd3;
    localparam logic [31:0] TokNop = 32'd4;

    localparam logic [1:0] VerdictUnknown = 2'd0;
    localparam logic [1:0] VerdictEmpty   = 2'd1;
    localparam logic [1:0] VerdictOpen    = 2'd2;
    localparam logic [1:0] VerdictVendor  = 2'd3;

    localparam int OpenLen   = 29;
    localparam int VendorLen = 34;

    function automatic logic [7:0] open_char(input logic [5:0] idx);
        logic [7:0] t [0:28];
        t = '{8'h41, 8'h72, 8'h74, 8'h6F, 8'h73, 8'h79, 8'h6E, 8'h20, 8'h50, 8'h72,
              8'h6F, 8'h78, 8'h69, 8'h6D, 8'h61, 8'h2D, 8'h39, 8'h33, 8'h31, 8'h31,
              8'h20, 8'h28, 8'h42, 8'h65, 8'h74, 8'h61, 8'h46, 8'h50, 8'h56};
        return (idx < 6'(OpenLen)) ? t[idx[4:0]] : 8'h00;
    endfunction

    function automatic logic [7:0] vendor_char(input logic [5:0] idx);
        logic [7:0] t [0:33];
        t = '{8'h41, 8'h72, 8'h74, 8'h6F, 8'h73, 8'h79, 8'h6E, 8'h2C, 8'h20, 8'h50,
              8'h72, 8'h6F, 8'h78, 8'h69, 8'h6D, 8'h61, 8'h20, 8'h44, 8'h65, 8'h76,
              8'h65, 8'h6C, 8'h6F, 8'h70, 8'h6D, 8'h65, 8'h6E, 8'h74, 8'h20, 8'h42,
              8'h6F, 8'h61, 8'h72, 8'h64};
        return (idx < 6'(VendorLen)) ? t[idx] : 8'h00;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h6D;
            3'd1: r = 8'h6F;
            3'd2: r = 8'h64;
            3'd3: r = 8'h65;
            3'd4: r = 8'h6C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] sanitize(input logic [7:0] c);
        logic bad;
        bad = (c < 8'h20) || (c > 8'h7E) || (c == 8'h22) || (c == 8'h5C);
        return bad ? 7'h3F : c[6:0];
    endfunction

endpackage

>>> sv/fdt_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module fdt_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/fdt_root_model_classifier_top.sv
// Top level of the device-tree root model classifier.
// Depends on fdt_pkg and fdt_ram (blob store and model buffer).
//
// Bytes of a partition head are transferred one per cycle (start high, busy low) and written
// into the blob store. On the byte marked last the block raises busy and judges the stream:
// it checks the header, walks the structure block through the single store read port (each
// store byte: address, then registered data), copies the root model text into the model
// buffer, compares it, then emits one strobe per model character and a final verdict strobe,
// one per cycle. The receiver cannot stall: each result is on the ports for exactly one
// cycle. Judging touches the header, the walked tokens, property names and the model text;
// the output run holds up to MODEL_MAX results. Bytes past BLOB_DEPTH are dropped, not
// counted.
module fdt_root_model_classifier_top
    import fdt_pkg::*;
#(
    parameter int BLOB_DEPTH   = BlobDepthDef,
    parameter int MODEL_MAX    = ModelMaxDef,
    parameter int HEADER_BYTES = HeaderBytesDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] i_blob_byte,
    input  logic       i_last_byte,
    output logic       o_strobe,
    output logic [6:0] o_model_char,
    output logic [1:0] o_verdict,
    output logic       o_model_found,
    output logic       o_final_item
);
    localparam int AW = $clog2(BLOB_DEPTH);
    localparam int CW = AW + 1;      // counts up to BLOB_DEPTH
    localparam int MW = $clog2(MODEL_MAX);
    localparam int LW = MW + 1;

    typedef enum logic [10:0] {
        S_LOAD   = 11'b00000000001,
        S_ERASED = 11'b00000000010,
        S_HDR    = 11'b00000000100,
        S_CHECK  = 11'b00000001000,
        S_TOK    = 11'b00000010000,
        S_DISP   = 11'b00000100000,
        S_NAME   = 11'b00001000000,
        S_KEY    = 11'b00010000000,
        S_COPY   = 11'b00100000000,
        S_CMP    = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Store byte fetch: r_fpend marks data returning this cycle for r_faddr.
    logic [33:0] r_faddr, n_faddr;
    logic        r_fpend, n_fpend;
    logic [31:0] r_word, n_word;
    logic [2:0]  r_bcnt, n_bcnt;     // bytes of word gathered
    logic [1:0]  r_wsel, n_wsel;     // header word in progress

    logic [CW-1:0] r_loaded, n_loaded;
    logic [CW-1:0] r_loaded_at_last;
    logic [31:0] r_total, n_total, r_soff, n_soff, r_stroff, n_stroff;
    logic [33:0] r_woff, n_woff;
    logic        r_depth, n_depth;   // inside root node
    logic [1:0]  r_tsub, n_tsub;     // token phase: tok, vlen, noff
    logic [31:0] r_tok, n_tok, r_vlen, n_vlen;
    logic [33:0] r_nptr, n_nptr, r_vend, n_vend;
    logic [2:0]  r_kidx, n_kidx;
    logic        r_inname, n_inname; // scanning a node name
    logic [LW-1:0] r_mlen, n_mlen;
    logic [LW-1:0] r_oidx, n_oidx;
    logic        r_open, n_open, r_vend_ok, n_vend_ok;
    logic        r_found, n_found;
    logic [1:0]  r_verd, n_verd;
    logic        r_rdpend, n_rdpend;  // model buffer read in flight

    logic        r_strobe, n_strobe;
    logic [6:0]  r_char, n_char;
    logic [1:0]  r_overd, n_overd;
    logic        r_ofound, n_ofound, r_ofinal, n_ofinal;

    logic              st_we;
    logic [AW-1:0]     st_addr;
    logic [7:0]        st_rdata;
    logic              mb_we;
    logic [MW-1:0]     mb_addr;
    logic [6:0]        mb_wdata, mb_rdata;

    logic accept;
    assign accept = start && !busy;
    assign busy   = (r_state != S_LOAD);

    fdt_ram #(.Width(8), .Depth(BLOB_DEPTH)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_addr(st_addr), .i_wdata(i_blob_byte),
        .o_rdata(st_rdata));

    fdt_ram #(.Width(7), .Depth(MODEL_MAX)) u_model (
        .i_clk(i_clk), .i_we(mb_we), .i_addr(mb_addr), .i_wdata(mb_wdata),
        .o_rdata(mb_rdata));

    // Byte beyond the store reads as zero.
    logic        f_oob;
    logic [7:0]  f_byte;
    assign f_oob  = (r_faddr >= 34'(BLOB_DEPTH));
    assign f_byte = f_oob ? 8'h00 : st_rdata;

    logic [33:0] tot34;
    assign tot34 = {2'b00, r_total};

    always_comb begin
        n_state = r_state; n_faddr = r_faddr; n_fpend = 1'b0; n_word = r_word;
        n_bcnt = r_bcnt; n_wsel = r_wsel; n_loaded = r_loaded; n_total = r_total;
        n_soff = r_soff; n_stroff = r_stroff; n_woff = r_woff; n_depth = r_depth;
        n_tsub = r_tsub; n_tok = r_tok; n_vlen = r_vlen; n_nptr = r_nptr; n_vend = r_vend;
        n_kidx = r_kidx; n_inname = r_inname; n_mlen = r_mlen; n_oidx = r_oidx;
        n_open = r_open; n_vend_ok = r_vend_ok; n_found = r_found; n_verd = r_verd;
        n_rdpend = 1'b0;
        n_strobe = 1'b0; n_char = '0; n_overd = '0; n_ofound = 1'b0; n_ofinal = 1'b0;
        st_we = 1'b0; st_addr = r_faddr[AW-1:0];
        mb_we = 1'b0; mb_addr = r_oidx[MW-1:0]; mb_wdata = '0;

        case (r_state)
            S_LOAD: begin
                st_addr = r_loaded[AW-1:0];
                if (accept) begin
                    if (r_loaded < CW'(BLOB_DEPTH)) begin
                        st_we = 1'b1;
                        n_loaded = r_loaded + 1'b1;
                    end
                    if (i_last_byte) begin
                        n_found = 1'b0; n_mlen = '0; n_oidx = '0;
                        if (n_loaded < CW'(HEADER_BYTES)) begin
                            n_verd = VerdictUnknown;
                            n_state = S_EMIT;
                        end else begin
                            n_faddr = '0; n_fpend = 1'b0;
                            n_state = S_ERASED;
                        end
                        n_loaded = '0;
                    end
                end
            end
            S_ERASED: begin
                // Scan header bytes for anything but 0xFF.
                if (!r_fpend) begin
                    st_addr = r_faddr[AW-1:0];
                    n_fpend = 1'b1;
                end else if (f_byte != 8'hFF) begin
                    n_faddr = '0; n_bcnt = '0; n_wsel = '0;
                    n_state = S_HDR;
                end else if (r_faddr == 34'(HEADER_BYTES - 1)) begin
                    n_verd = VerdictEmpty;
                    n_state = S_EMIT;
                end else begin
                    n_faddr = r_faddr + 1'b1;
                end
            end
            S_HDR: begin
                // Gather header words magic, total, struct offset, strings offset.
                if (!r_fpend) begin
                    st_addr = r_faddr[AW-1:0];
                    n_fpend = 1'b1;
                end else begin
                    n_word = {r_word[23:0], f_byte};
                    n_faddr = r_faddr + 1'b1;
                    n_bcnt = r_bcnt + 1'b1;
                    if (r_bcnt == 3'd3) begin
                        n_bcnt = '0;
                        n_wsel = r_wsel + 1'b1;
                        case (r_wsel)
                            2'd0: if (n_word != FdtMagic) begin
                                n_verd = VerdictUnknown; n_state = S_EMIT;
                            end
                            2'd1: n_total = n_word;
                            2'd2: n_soff = n_word;
                            default: begin
                                n_stroff = n_word;
                                n_state = S_CHECK;
                            end
                        endcase
                    end
                end
            end
            S_CHECK: begin
                n_verd = VerdictUnknown;
                if (r_total < 32'd40 || {2'b00, r_total} > 34'(BLOB_DEPTH) ||
                    {1'b0, r_total} > 33'(r_loaded_at_last)) begin
                    n_state = S_EMIT;
                end else if (r_soff >= r_total || r_stroff >= r_total) begin
                    n_state = S_EMIT;
                end else begin
                    n_woff = {2'b00, r_soff}; n_depth = 1'b0; n_inname = 1'b0;
                    n_faddr = {2'b00, r_soff}; n_tsub = '0; n_bcnt = '0;
                    n_state = S_TOK;
                end
            end
            S_TOK: begin
                if (r_inname) begin
                    // Skip node name up to its zero byte, then align.
                    if (r_faddr >= tot34) begin
                        n_woff = (r_faddr + 34'd4) & ~34'd3;
                        n_faddr = n_woff; n_inname = 1'b0; n_bcnt = '0;
                    end else if (!r_fpend) begin
                        st_addr = r_faddr[AW-1:0];
                        n_fpend = 1'b1;
                    end else if (f_byte == 8'h00) begin
                        n_woff = (r_faddr + 34'd4) & ~34'd3;
                        n_faddr = n_woff; n_inname = 1'b0; n_bcnt = '0;
                    end else begin
                        n_faddr = r_faddr + 1'b1;
                    end
                end else if (r_bcnt == 3'd0 && !r_fpend &&
                             (r_woff + 34'd4 > tot34 ||
                              (r_tsub == 2'd1 && r_woff + 34'd8 > tot34))) begin
                    n_state = S_EMIT;
                end else if (!r_fpend) begin
                    st_addr = r_faddr[AW-1:0];
                    n_fpend = 1'b1;
                end else begin
                    n_word = {r_word[23:0], f_byte};
                    n_faddr = r_faddr + 1'b1;
                    n_bcnt = r_bcnt + 1'b1;
                    if (r_bcnt == 3'd3) begin
                        n_bcnt = '0;
                        n_woff = r_woff + 34'd4;
                        n_state = S_DISP;
                    end
                end
            end
            S_DISP: begin
                n_state = S_TOK;
                case (r_tsub)
                    2'd0: begin
                        n_tok = r_word;
                        if (r_word == TokNop) begin
                            n_state = S_TOK;
                        end else if (r_word == TokEndNode) begin
                            n_state = S_EMIT; // depth is at most one: leaving root fails
                        end else if (r_word == TokBegin) begin
                            if (r_depth) begin
                                n_state = S_EMIT;
                            end else begin
                                n_depth = 1'b1; n_inname = 1'b1;
                            end
                        end else if (r_word == TokProp) begin
                            n_tsub = 2'd1;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    2'd1: begin
                        n_vlen = r_word; n_tsub = 2'd2;
                    end
                    default: begin
                        n_tsub = 2'd0;
                        if (r_woff + {2'b00, r_vlen} > tot34 ||
                            {2'b00, r_stroff} + {2'b00, r_word} >= tot34) begin
                            n_state = S_EMIT;
                        end else if (r_depth) begin
                            n_nptr = {2'b00, r_stroff} + {2'b00, r_word};
                            n_faddr = n_nptr; n_kidx = '0;
                            n_state = S_NAME;
                        end else begin
                            n_woff = (r_woff + {2'b00, r_vlen} + 34'd3) & ~34'd3;
                            n_faddr = n_woff;
                        end
                    end
                endcase
            end
            S_NAME: begin
                // Compare property name against "model" plus terminator.
                if (r_faddr >= tot34) begin
                    n_state = S_KEY;
                    n_kidx = 3'd7;
                end else if (!r_fpend) begin
                    st_addr = r_faddr[AW-1:0];
                    n_fpend = 1'b1;
                end else if (f_byte != key_char(r_kidx)) begin
                    n_state = S_KEY; n_kidx = 3'd7;
                end else if (r_kidx == 3'd5) begin
                    n_state = S_KEY;
                end else begin
                    n_kidx = r_kidx + 1'b1;
                    n_faddr = r_faddr + 1'b1;
                end
            end
            S_KEY: begin
                if (r_kidx == 3'd5) begin
                    n_faddr = r_woff; n_vend = r_woff + {2'b00, r_vlen};
                    n_mlen = '0; n_found = 1'b1; n_open = 1'b1; n_vend_ok = 1'b1;
                    n_state = S_COPY;
                end else begin
                    n_woff = (r_woff + {2'b00, r_vlen} + 34'd3) & ~34'd3;
                    n_faddr = n_woff; n_bcnt = '0;
                    n_state = S_TOK;
                end
            end
            S_COPY: begin
                if (r_faddr >= r_vend || r_mlen == LW'(MODEL_MAX - 1)) begin
                    n_state = S_CMP;
                end else if (!r_fpend) begin
                    st_addr = r_faddr[AW-1:0];
                    n_fpend = 1'b1;
                end else if (f_byte == 8'h00) begin
                    n_state = S_CMP;
                end else begin
                    mb_we = 1'b1; mb_addr = r_mlen[MW-1:0]; mb_wdata = sanitize(f_byte);
                    if (r_mlen < LW'(OpenLen) &&
                        {1'b0, mb_wdata} != open_char(6'(r_mlen))) n_open = 1'b0;
                    if (r_mlen >= LW'(VendorLen) ||
                        {1'b0, mb_wdata} != vendor_char(6'(r_mlen))) n_vend_ok = 1'b0;
                    n_mlen = r_mlen + 1'b1;
                    n_faddr = r_faddr + 1'b1;
                end
            end
            S_CMP: begin
                if (r_open && r_mlen >= LW'(OpenLen)) n_verd = VerdictOpen;
                else if (r_vend_ok && r_mlen == LW'(VendorLen)) n_verd = VerdictVendor;
                else n_verd = VerdictUnknown;
                n_oidx = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                // Read model buffer one ahead; data returns the next cycle.
                mb_addr = r_oidx[MW-1:0];
                if (r_found && r_oidx < r_mlen) begin
                    n_rdpend = 1'b1;
                    n_oidx = r_oidx + 1'b1;
                end else if (!r_rdpend) begin
                    n_strobe = 1'b1; n_overd = r_verd; n_ofound = r_found; n_ofinal = 1'b1;
                    n_state = S_LOAD;
                end
                if (r_rdpend) begin
                    n_strobe = 1'b1; n_char = mb_rdata; n_ofound = 1'b1;
                end
            end
            default: n_state = S_LOAD;
        endcase
        if (r_state != S_EMIT && n_state == S_EMIT) begin
            n_oidx = '0;
            if (!(r_state == S_CMP)) n_found = 1'b0;
        end
    end

    // Bytes loaded in the run, latched on the last transfer for the size check.
    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_loaded_at_last <= (r_loaded < CW'(BLOB_DEPTH)) ? r_loaded + 1'b1 : r_loaded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_loaded <= '0; r_fpend <= 1'b0; r_strobe <= 1'b0;
            r_rdpend <= 1'b0; r_found <= 1'b0; r_mlen <= '0; r_oidx <= '0;
            r_ofinal <= 1'b0;
        end else begin
            r_state <= n_state; r_loaded <= n_loaded; r_fpend <= n_fpend;
            r_strobe <= n_strobe; r_rdpend <= n_rdpend; r_found <= n_found;
            r_mlen <= n_mlen; r_oidx <= n_oidx; r_ofinal <= n_ofinal;
        end
    end

    always_ff @(posedge i_clk) begin
        r_faddr <= n_faddr; r_word <= n_word; r_bcnt <= n_bcnt; r_wsel <= n_wsel;
        r_total <= n_total; r_soff <= n_soff; r_stroff <= n_stroff; r_woff <= n_woff;
        r_depth <= n_depth; r_tsub <= n_tsub; r_tok <= n_tok; r_vlen <= n_vlen;
        r_nptr <= n_nptr; r_vend <= n_vend; r_kidx <= n_kidx; r_inname <= n_inname;
        r_open <= n_open; r_vend_ok <= n_vend_ok; r_verd <= n_verd;
        r_char <= n_char; r_overd <= n_overd; r_ofound <= n_ofound;
    end

    assign o_strobe      = r_strobe;
    assign o_model_char  = r_char;
    assign o_verdict     = r_overd;
    assign o_model_found = r_ofound;
    assign o_final_item  = r_ofinal;

    a_final_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ofinal |-> r_strobe) else $error("final item without strobe");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> busy) else $error("busy low while judging");
    a_idle_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ofinal |-> !busy) else $error("block busy after verdict");
    a_mlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mlen <= LW'(MODEL_MAX - 1)) else $error("model length overflow");
endmodule

>>> dv/tb_fdt_root_model_classifier_top.sv
// Self-checking testbench for fdt_root_model_classifier_top.
// Depends on fdt_pkg; builds device-tree heads, predicts model text and verdicts, checks strobes.
module tb_fdt_root_model_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdt_pkg::*;

    localparam logic [31:0] TOK_END = 32'd9;
    localparam int STORE_DEPTH = BlobDepthDef;

    // Model strings as byte tables (prefix of the open build, exact vendor board name).
    localparam logic [7:0] OPEN_TXT [0:28] = '{
        8'h41, 8'h72, 8'h74, 8'h6F, 8'h73, 8'h79, 8'h6E, 8'h20, 8'h50, 8'h72,
        8'h6F, 8'h78, 8'h69, 8'h6D, 8'h61, 8'h2D, 8'h39, 8'h33, 8'h31, 8'h31,
        8'h20, 8'h28, 8'h42, 8'h65, 8'h74, 8'h61, 8'h46, 8'h50, 8'h56};
    localparam logic [7:0] VENDOR_TXT [0:33] = '{
        8'h41, 8'h72, 8'h74, 8'h6F, 8'h73, 8'h79, 8'h6E, 8'h2C, 8'h20, 8'h50,
        8'h72, 8'h6F, 8'h78, 8'h69, 8'h6D, 8'h61, 8'h20, 8'h44, 8'h65, 8'h76,
        8'h65, 8'h6C, 8'h6F, 8'h70, 8'h6D, 8'h65, 8'h6E, 8'h74, 8'h20, 8'h42,
        8'h6F, 8'h61, 8'h72, 8'h64};
    localparam logic [7:0] prop_model_name [0:5] = '{8'h6D, 8'h6F, 8'h64, 8'h65, 8'h6C, 8'h00};

    typedef struct {
        logic [6:0] model_char;
        logic [1:0] verdict;
        logic       model_found;
        logic       final_item;
    } t_cls_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [7:0] i_blob_byte;
    logic       i_last_byte;
    logic       o_strobe;
    logic [6:0] o_model_char;
    logic [1:0] o_verdict;
    logic       o_model_found;
    logic       o_final_item;

    fdt_root_model_classifier_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_blob_byte  (i_blob_byte),
        .i_last_byte  (i_last_byte),
        .o_strobe     (o_strobe),
        .o_model_char (o_model_char),
        .o_verdict    (o_verdict),
        .o_model_found(o_model_found),
        .o_final_item (o_final_item)
    );

    // Pending byte transfers, filled up front by the stimulus block.
    logic [7:0] pend_byte [$];
    logic       pend_last [$];
    // Results the predictor expects, oldest first.
    t_cls_result expected_results [$];

    // Predictor state: its own copy of the blob store and the extracted model text.
    logic [7:0] flash_img [0:STORE_DEPTH-1];
    int         bytes_loaded = 0;
    logic [6:0] model_txt [$];

    // Image under construction by the stimulus tasks.
    logic [7:0] blob [$];
    logic [7:0] mtext [$];

    bit fail = 0;
    int burst_left = 1;
    int gap_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        start       = 1'b0;
        i_blob_byte = 8'h00;
        i_last_byte = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic logic [7:0] img_at(longint a);
        return (a < STORE_DEPTH) ? flash_img[a] : 8'h00;
    endfunction

    function automatic longint word_at(longint a);
        return {img_at(a), img_at(a + 1), img_at(a + 2), img_at(a + 3)};
    endfunction

    // Copy the model value, stopping at NUL, at the value length or at the buffer limit.
    function automatic void copy_model(longint at, longint vlen);
        logic [7:0] c;
        model_txt.delete();
        for (longint i = 0; i < vlen && model_txt.size() + 1 < ModelMaxDef; i++) begin
            c = img_at(at + i);
            if (c == 8'h00) break;
            if (c < 8'h20 || c > 8'h7E || c == 8'h22 || c == 8'h5C) c = 8'h3F;
            model_txt.push_back(c[6:0]);
        end
    endfunction

    function automatic bit name_is_model(longint at, longint len);
        logic [7:0] key [0:5];
        key = '{8'h6D, 8'h6F, 8'h64, 8'h65, 8'h6C, 8'h00};
        for (int k = 0; k < 6; k++)
            if (at + k >= len || img_at(at + k) != key[k]) return 1'b0;
        return 1'b1;
    endfunction

    // Walk the structure block up to the root node's model property.
    function automatic bit walk_to_model(longint len);
        longint soff, stroff, off, tok, e, vlen, noff;
        int depth;
        soff = word_at(8);
        stroff = word_at(12);
        if (soff >= len || stroff >= len) return 1'b0;
        off = soff;
        depth = 0;
        while (off + 4 <= len) begin
            tok = word_at(off);
            off += 4;
            if (tok == TokNop) continue;
            if (tok == TOK_END) return 1'b0;
            if (tok == TokEndNode) begin
                if (depth <= 1) return 1'b0;
                depth--;
                continue;
            end
            if (tok == TokBegin) begin
                if (depth >= 1) return 1'b0;
                depth = 1;
                e = off;
                while (e < len && img_at(e) != 8'h00) e++;
                off = (e + 4) & ~longint'(3);
                continue;
            end
            if (tok == TokProp) begin
                if (off + 8 > len) return 1'b0;
                vlen = word_at(off);
                noff = word_at(off + 4);
                off += 8;
                if (off + vlen > len || stroff + noff >= len) return 1'b0;
                if (depth == 1 && name_is_model(stroff + noff, len)) begin
                    copy_model(off, vlen);
                    return 1'b1;
                end
                off = (off + vlen + 3) & ~longint'(3);
                continue;
            end
            return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic logic [1:0] classify(output bit found);
        bit erased, same;
        longint total;
        found = 1'b0;
        model_txt.delete();
        if (bytes_loaded < HeaderBytesDef) return VerdictUnknown;
        erased = 1'b1;
        for (int i = 0; i < HeaderBytesDef; i++)
            if (img_at(i) != 8'hFF) erased = 1'b0;
        if (erased) return VerdictEmpty;
        if (word_at(0) != FdtMagic) return VerdictUnknown;
        total = word_at(4);
        if (total < 40 || total > STORE_DEPTH) return VerdictUnknown;
        if (bytes_loaded < total) return VerdictUnknown;
        if (!walk_to_model(total)) return VerdictUnknown;
        found = 1'b1;
        if (model_txt.size() >= 29) begin
            same = 1'b1;
            for (int i = 0; i < 29; i++)
                if (model_txt[i] != OPEN_TXT[i][6:0]) same = 1'b0;
            if (same) return VerdictOpen;
        end
        if (model_txt.size() == 34) begin
            same = 1'b1;
            for (int i = 0; i < 34; i++)
                if (model_txt[i] != VENDOR_TXT[i][6:0]) same = 1'b0;
            if (same) return VerdictVendor;
        end
        return VerdictUnknown;
    endfunction

    // Store one accepted byte; on the last byte queue the model characters and the verdict.
    function automatic void predict_byte(logic [7:0] b, logic last);
        t_cls_result r;
        logic [1:0] v;
        bit found;
        if (bytes_loaded < STORE_DEPTH) flash_img[bytes_loaded] = b;
        bytes_loaded++;
        if (!last) return;
        v = classify(found);
        if (found) begin
            foreach (model_txt[i]) begin
                r = '{model_char: model_txt[i], verdict: VerdictUnknown,
                      model_found: 1'b1, final_item: 1'b0};
                expected_results.push_back(r);
            end
        end
        r = '{model_char: 7'd0, verdict: v, model_found: found, final_item: 1'b1};
        expected_results.push_back(r);
        bytes_loaded = 0;
    endfunction

    // ---------------- driver ----------------
    // Transfer when start is high and busy low; bursts of random length, random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_byte(i_blob_byte, i_last_byte);
                void'(pend_byte.pop_front());
                void'(pend_last.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pend_byte.size() > 0) begin
                start       <= 1'b1;
                i_blob_byte <= pend_byte[0];
                i_last_byte <= pend_last[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    // Half of the bursts run straight into the next one.
                    gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        t_cls_result exp_r;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result char=%h verdict=%0d found=%0d final=%0d",
                         $time, o_model_char, o_verdict, o_model_found, o_final_item);
                fail = 1'b1;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_model_char !== exp_r.model_char) begin
                    $display("%0t: model_char expected %h actual %h",
                             $time, exp_r.model_char, o_model_char);
                    fail = 1'b1;
                end
                if (o_verdict !== exp_r.verdict) begin
                    $display("%0t: verdict expected %0d actual %0d",
                             $time, exp_r.verdict, o_verdict);
                    fail = 1'b1;
                end
                if (o_model_found !== exp_r.model_found) begin
                    $display("%0t: model_found expected %0d actual %0d",
                             $time, exp_r.model_found, o_model_found);
                    fail = 1'b1;
                end
                if (o_final_item !== exp_r.final_item) begin
                    $display("%0t: final_item expected %0d actual %0d",
                             $time, exp_r.final_item, o_final_item);
                    fail = 1'b1;
                end
            end
        end
    end

    // ---------------- image builders ----------------
    task automatic put32(input logic [31:0] w);
        blob.push_back(w[31:24]);
        blob.push_back(w[23:16]);
        blob.push_back(w[15:8]);
        blob.push_back(w[7:0]);
    endtask

    task automatic set32(input int at, input logic [31:0] w);
        blob[at]     = w[31:24];
        blob[at + 1] = w[23:16];
        blob[at + 2] = w[15:8];
        blob[at + 3] = w[7:0];
    endtask

    // Model text: open prefix with a tail, exact vendor name, near-miss vendor, or random.
    task automatic pick_model(input int kind);
        int n;
        mtext.delete();
        case (kind)
            0: begin
                foreach (OPEN_TXT[i]) mtext.push_back(OPEN_TXT[i]);
                repeat ($urandom_range(0, 40))
                    mtext.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end
            1: foreach (VENDOR_TXT[i]) mtext.push_back(VENDOR_TXT[i]);
            2: begin
                foreach (VENDOR_TXT[i]) mtext.push_back(VENDOR_TXT[i]);
                if ($urandom_range(0, 1)) void'(mtext.pop_back());
                else mtext[$urandom_range(0, 33)] = 8'($urandom_range(1, 255));
            end
            default: begin
                n = $urandom_range(0, 70);
                repeat (n) mtext.push_back(8'($urandom_range(1, 255)));
            end
        endcase
    endtask

    // Build a well-formed head: root node, optional extra property, then the model property.
    task automatic build_fdt(input bit with_nul, input bit extra_prop);
        int stroff;
        int slen;
        string names;
        names = "compatible";
        blob.delete();
        repeat (10) put32(32'd0);
        repeat ($urandom_range(0, 2)) put32(TokNop);
        put32(TokBegin);
        put32(32'd0);
        if (extra_prop) begin
            put32(TokProp);
            put32(32'd4);
            put32(32'd6);
            put32(32'h61626300);
        end
        put32(TokProp);
        put32(mtext.size() + with_nul);
        put32(32'd0);
        foreach (mtext[i]) blob.push_back(mtext[i]);
        if (with_nul) blob.push_back(8'h00);
        while (blob.size() % 4 != 0) blob.push_back(8'h00);
        put32(TokEndNode);
        put32(TOK_END);
        stroff = blob.size();
        foreach (prop_model_name[i]) blob.push_back(prop_model_name[i]);
        for (int i = 0; i < names.len(); i++) blob.push_back(names[i]);
        blob.push_back(8'h00);
        slen = blob.size() - stroff;
        while (blob.size() < 64) blob.push_back(8'h00);
        set32(0, FdtMagic);
        set32(4, blob.size());
        set32(8, 32'd40);
        set32(12, stroff);
        set32(16, 32'd40);
        set32(20, 32'd17);
        set32(24, 32'd16);
        set32(32, slen);
        set32(36, stroff - 40);
    endtask

    // Queue n bytes of the image (random filler past its end), the final one marked last.
    task automatic send_blob(input int n);
        for (int i = 0; i < n; i++) begin
            pend_byte.push_back(i < blob.size() ? blob[i] : 8'($urandom_range(0, 255)));
            pend_last.push_back(i == n - 1);
        end
    endtask

    task automatic send_random(input int n, input logic [7:0] fill, input bit rnd);
        blob.delete();
        repeat (n) blob.push_back(rnd ? 8'($urandom_range(0, 255)) : fill);
        send_blob(n);
    endtask

    task automatic random_run();
        int m;
        pick_model($urandom_range(0, 3));
        build_fdt($urandom_range(0, 3) != 0, $urandom_range(0, 1));
        m = $urandom_range(0, 11);
        case (m)
            6: blob[$urandom_range(0, blob.size() - 1)] = 8'($urandom_range(0, 255));
            7: begin
                send_blob($urandom_range(1, blob.size() - 1));
                return;
            end
            8: begin
                send_blob(blob.size() + $urandom_range(1, 8));
                return;
            end
            9: set32(4, $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom());
            10: begin
                if ($urandom_range(0, 1)) send_random(64 + $urandom_range(0, 4), 8'hFF, 0);
                else send_random($urandom_range(1, 70), 8'h00, 1);
                return;
            end
            11: set32(8, $urandom_range(0, 1) ? $urandom_range(40, 80) & ~3 : $urandom());
            default: ;
        endcase
        send_blob(blob.size());
    endtask

    // ---------------- stimulus, end of run ----------------
    initial begin
        i_rst_n = 1'b0;

        // Short head of one byte, erased head, exact vendor model, short head of 16 bytes.
        send_random(1, 8'h00, 1);
        send_random(64, 8'hFF, 0);
        pick_model(1); build_fdt(1, 0); send_blob(blob.size());
        send_random(16, 8'h00, 1);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pend_byte.size() == 0);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!fail) begin
            $display("tb_fdt_root_model_classifier_top: PASS");
        end else begin
            $display("tb_fdt_root_model_classifier_top: FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_fdt_root_model_classifier_top: FAIL");
        $finish;
    end

endmodule
